// ===== hw/rtl/bbc_pkg.sv =====
// Shared constants, types and a decode function for the bracket balance checker.
package bbc_pkg;

  localparam int unsigned StackDepthDefault = 64;

  localparam logic [7:0] CharLBrace = 8'h7B;  // {
  localparam logic [7:0] CharRBrace = 8'h7D;  // }
  localparam logic [7:0] CharLParen = 8'h28;  // (
  localparam logic [7:0] CharRParen = 8'h29;  // )
  localparam logic [7:0] CharLBrack = 8'h5B;  // [
  localparam logic [7:0] CharRBrack = 8'h5D;  // ]

  typedef enum logic [1:0] {
    KIND_BRACE = 2'd0,
    KIND_PAREN = 2'd1,
    KIND_BRACK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISMATCH  = 3'd1,
    ERR_UNMATCHED = 3'd2,
    ERR_UNCLOSED  = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_e;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } decode_t;

  function automatic decode_t decode_char(input logic [7:0] c);
    decode_t d;
    d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_BRACE};
    case (c)
      CharLBrace: d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
      CharLParen: d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CharLBrack: d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACK};
      CharRBrace: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
      CharRParen: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CharRBrack: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACK};
      default:    d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_BRACE};
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/bbc_stream_if.sv =====
// Valid/ready stream interfaces for the character input and the verdict output.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source(output valid, output char_code, output end_of_string, input ready);
  modport sink(input valid, input char_code, input end_of_string, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] error_kind;

  modport source(output valid, output balanced, output error_kind, input ready);
  modport sink(input valid, input balanced, input error_kind, output ready);
endinterface

// ===== hw/rtl/bracket_balance_checker.sv =====
// Bracket balance checker: scans a character stream and reports nesting errors.
//
// Input channel in_i carries one character per item plus an end_of_string
// flag. Opening brackets push their kind onto a stack held in a RAM, closing
// brackets pop it and compare. Only the last item of a string produces a
// result on out_o: balanced and error_kind (0 ok, 1 kind mismatch,
// 2 unmatched close, 3 unclosed open, 4 stack overflow).
// Throughput is one item per cycle, except that a last character waits while
// the output register holds an unread verdict. The top of stack sits in a
// register and the RAM read port fetches the entry below it ahead of time, so a
// pop finds its next top without waiting on the read latency. The verdict is
// registered and appears on out_o in the cycle after the last item is accepted.
// Reset empties the stack and clears the error state at once; no clearing
// pass runs, the RAM keeps stale contents that are never read.
// When the receiver stalls, the verdict holds in the output register;
// characters that are not the end of a string are still taken, a last
// character waits until the output register is free.
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [DepthW-1:0] depth_q, depth_d;
  err_e              err_q, err_d;
  kind_e             top_q, top_d;
  logic              out_valid_q;
  logic              balanced_q;
  err_e              out_err_q;

  decode_t           dec;
  logic              in_acc;
  logic              out_free;
  logic              ram_we;
  logic [1:0]        second;
  logic [DepthW-1:0] raddr_full;
  err_e              res_err;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = out_free || !in_i.end_of_string;
  assign in_acc    = in_i.valid && in_i.ready;
  assign dec       = decode_char(in_i.char_code);

  always_comb begin
    depth_d = depth_q;
    err_d   = err_q;
    top_d   = top_q;
    ram_we  = 1'b0;
    res_err = ERR_NONE;
    if (in_acc) begin
      if (err_q == ERR_NONE) begin
        if (dec.is_open) begin
          if (depth_q == DepthW'(STACK_DEPTH)) begin
            err_d = ERR_OVERFLOW;
          end else begin
            ram_we  = 1'b1;
            top_d   = dec.kind;
            depth_d = depth_q + DepthW'(1);
          end
        end else if (dec.is_close) begin
          if (depth_q == '0) begin
            err_d = ERR_UNMATCHED;
          end else begin
            // pop: the prefetched entry below becomes the new top
            depth_d = depth_q - DepthW'(1);
            top_d   = kind_e'(second);
            if (top_q != dec.kind) begin
              err_d = ERR_MISMATCH;
            end
          end
        end
      end
      res_err = err_d;
      if (res_err == ERR_NONE && depth_d != '0) begin
        res_err = ERR_UNCLOSED;
      end
      if (in_i.end_of_string) begin
        depth_d = '0;
        err_d   = ERR_NONE;
      end
    end
  end

  // prefetch the entry just below the top of the next state
  assign raddr_full = depth_d - DepthW'(2);

  bbc_ram #(
    .Width(2),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(depth_q[AddrW-1:0]),
    .wdata_i(dec.kind),
    .raddr_i(raddr_full[AddrW-1:0]),
    .rdata_o(second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      err_q   <= err_d;
      if (in_acc && in_i.end_of_string) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_acc && in_i.end_of_string) begin
      balanced_q <= (res_err == ERR_NONE);
      out_err_q  <= res_err;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.balanced   = balanced_q;
  assign out_o.error_kind = out_err_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.end_of_string |=> depth_q == '0 && err_q == ERR_NONE)
    else $error("state not cleared after last item");

  a_hold_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.end_of_string && err_q != ERR_NONE |=> $stable(depth_q) && $stable(err_q))
    else $error("state changed after an error");

  a_verdict_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> balanced_q == (out_err_q == ERR_NONE))
    else $error("balanced flag disagrees with error code");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !(in_acc && in_i.end_of_string))
    else $error("pending verdict overwritten");

endmodule

// ===== hw/rtl/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/bracket_balance_checker_tb.sv =====
// Self-checking testbench for the bracket balance checker: directed and random strings vs. a stack predictor.
`timescale 1ns / 100ps

module bracket_balance_checker_tb;
  import bbc_pkg::*;

  localparam int unsigned StackDepth = StackDepthDefault;
  localparam int ItemTarget = 1850;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
    logic       drain_first;
  } char_item_t;

  typedef struct packed {
    logic balanced;
    err_e error_kind;
  } verdict_t;

  typedef enum logic [1:0] {
    READY_FREE,
    READY_COIN,
    READY_SPARSE,
    READY_COMB
  } ready_mode_e;

  typedef enum logic [1:0] {
    FLAW_SWAP_CLOSE,
    FLAW_DROP_TAIL,
    FLAW_EXTRA_CLOSE,
    FLAW_EXTRA_OPEN
  } flaw_e;

  logic clk_i;
  logic rst_ni;

  bbc_in_if  in_if ();
  bbc_out_if out_if ();

  bracket_balance_checker #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  char_item_t  pending_chars[$];
  verdict_t    verdicts_due[$];
  int          total_items;
  int          accepted_count;
  int          bad_verdicts;
  logic        in_fire;

  // Predictor state: one open string at a time
  kind_e       open_stack[StackDepth];
  int unsigned open_depth;
  err_e        first_err;

  // Sender and receiver pacing
  int          burst_left;
  int          gap_left;
  ready_mode_e ready_mode;
  int          ready_span;
  int          quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void scan_char(input logic [7:0] c, input logic last,
                                    output bit has_verdict, output verdict_t v);
    logic  is_open;
    logic  is_close;
    kind_e kind;
    err_e  err;
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = KIND_BRACE;
    case (c)
      CharLBrace: begin is_open = 1'b1;  kind = KIND_BRACE; end
      CharLParen: begin is_open = 1'b1;  kind = KIND_PAREN; end
      CharLBrack: begin is_open = 1'b1;  kind = KIND_BRACK; end
      CharRBrace: begin is_close = 1'b1; kind = KIND_BRACE; end
      CharRParen: begin is_close = 1'b1; kind = KIND_PAREN; end
      CharRBrack: begin is_close = 1'b1; kind = KIND_BRACK; end
      default: ;
    endcase
    // Once an error is latched the rest of the string is ignored
    if (first_err == ERR_NONE) begin
      if (is_open) begin
        if (open_depth >= StackDepth) begin
          first_err = ERR_OVERFLOW;
        end else begin
          open_stack[open_depth] = kind;
          open_depth++;
        end
      end else if (is_close) begin
        if (open_depth == 0) begin
          first_err = ERR_UNMATCHED;
        end else begin
          open_depth--;
          if (open_stack[open_depth] != kind) first_err = ERR_MISMATCH;
        end
      end
    end
    has_verdict = last;
    v = '{balanced: 1'b0, error_kind: ERR_NONE};
    if (last) begin
      err = first_err;
      if (err == ERR_NONE && open_depth != 0) err = ERR_UNCLOSED;
      v.balanced   = (err == ERR_NONE);
      v.error_kind = err;
      open_depth = 0;
      first_err  = ERR_NONE;
    end
  endfunction

  function automatic logic [7:0] open_char(input kind_e k);
    case (k)
      KIND_PAREN: return CharLParen;
      KIND_BRACK: return CharLBrack;
      default:    return CharLBrace;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_e k);
    case (k)
      KIND_PAREN: return CharRParen;
      KIND_BRACK: return CharRBrack;
      default:    return CharRBrace;
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    c = 8'h00;
    forever begin
      c = 8'($urandom_range(0, 255));
      case (c)
        CharLBrace, CharRBrace, CharLParen, CharRParen, CharLBrack, CharRBrack: ;
        default: return c;
      endcase
    end
    return c;
  endfunction

  task automatic add_bytes(input logic [7:0] s[$], input bit drain);
    char_item_t it;
    for (int i = 0; i < s.size(); i++) begin
      it.char_code     = s[i];
      it.end_of_string = (i == s.size() - 1);
      it.drain_first   = drain && (i == 0);
      pending_chars.push_back(it);
    end
  endtask

  task automatic add_text(input string txt, input bit drain);
    logic [7:0] s[$];
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    add_bytes(s, drain);
  endtask

  task automatic add_random_string();
    logic [7:0] s[$];
    kind_e      opens[$];
    kind_e      k;
    int         shape;
    int         len;
    int         max_nest;
    int         pick;
    int         pos;
    flaw_e      flaw;
    shape = $urandom_range(0, 99);
    if (shape < 4) begin
      // Nest right around the stack limit: up to two below, full, or up to two over
      max_nest = $urandom_range(StackDepth - 2, StackDepth + 2);
      for (int i = 0; i < max_nest; i++) begin
        k = kind_e'($urandom_range(0, 2));
        opens.push_back(k);
        s.push_back(open_char(k));
      end
      while (opens.size() > 0) s.push_back(close_char(opens.pop_back()));
    end else if (shape < 20) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      len      = $urandom_range(0, 16);
      max_nest = ($urandom_range(0, 9) == 0) ? 12 : 4;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 2);
        if (pick == 0 && opens.size() < max_nest) begin
          k = kind_e'($urandom_range(0, 2));
          opens.push_back(k);
          s.push_back(open_char(k));
        end else if (pick == 1 && opens.size() > 0) begin
          s.push_back(close_char(opens.pop_back()));
        end else begin
          s.push_back(filler_char());
        end
      end
      while (opens.size() > 0) s.push_back(close_char(opens.pop_back()));
      // Add a flaw to about seven in sixteen of the well-formed strings
      if (shape >= 65 && s.size() > 0) begin
        flaw = flaw_e'($urandom_range(0, 3));
        pos  = $urandom_range(0, s.size() - 1);
        case (flaw)
          FLAW_SWAP_CLOSE:  s[pos] = close_char(kind_e'($urandom_range(0, 2)));
          FLAW_DROP_TAIL:   s.delete(s.size() - 1);
          FLAW_EXTRA_CLOSE: s.insert(pos, close_char(kind_e'($urandom_range(0, 2))));
          default:          s.insert(pos, open_char(kind_e'($urandom_range(0, 2))));
        endcase
      end
    end
    if (s.size() == 0) s.push_back(filler_char());
    add_bytes(s, $urandom_range(0, 29) == 0);
  endtask

  // Stimulus, reset and end of run
  initial begin
    logic [7:0] edge_bytes[$];
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.char_code        = 8'h00;
    in_if.end_of_string    = 1'b0;
    out_if.ready           = 1'b0;
    in_fire                = 1'b0;
    open_depth             = 0;
    first_err              = ERR_NONE;
    accepted_count         = 0;
    bad_verdicts           = 0;
    burst_left             = 1;
    gap_left               = 0;
    ready_mode             = READY_FREE;
    ready_span             = 0;
    quiet_cycles           = 0;

    add_text("a", 1'b0);
    edge_bytes = '{8'h00, 8'hFF};
    add_bytes(edge_bytes, 1'b0);
    add_text("()", 1'b0);
    add_text("{[()]}", 1'b0);
    add_text(")", 1'b1);
    add_text("(]", 1'b0);
    add_text("{)", 1'b0);
    add_text("[", 1'b0);
    add_text("}(", 1'b0);
    while (pending_chars.size() < ItemTarget) add_random_string();
    total_items = pending_chars.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count < total_items) @(negedge clk_i);
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (bad_verdicts == 0) begin
      $display("PASS bracket_balance_checker");
    end else begin
      $display("FAIL bracket_balance_checker");
    end
    $finish;
  end

  // Driver: bursts of items with random gaps
  always @(negedge clk_i) begin
    char_item_t nxt;
    logic       send;
    if (rst_ni && !(in_if.valid && !in_fire)) begin
      send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_chars.size() > 0 &&
                   !(pending_chars[0].drain_first && verdicts_due.size() != 0)) begin
        nxt  = pending_chars.pop_front();
        send = 1'b1;
        in_if.char_code     <= nxt.char_code;
        in_if.end_of_string <= nxt.end_of_string;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_if.valid <= send;
    end
  end

  // Receiver: stall pattern switches among four modes, each held for a random span
  always @(negedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_span = $urandom_range(16, 80);
    end else begin
      ready_span--;
    end
    case (ready_mode)
      READY_FREE:   out_if.ready <= 1'b1;
      READY_COIN:   out_if.ready <= ($urandom_range(0, 1) == 0);
      READY_SPARSE: out_if.ready <= ($urandom_range(0, 7) == 0);
      default:      out_if.ready <= (ready_span[3:0] == 4'd0);
    endcase
  end

  // Monitor: predict on accepted characters, check each verdict in order
  always @(posedge clk_i) begin
    bit       has_verdict;
    verdict_t v;
    verdict_t want;
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        accepted_count++;
        scan_char(in_if.char_code, in_if.end_of_string, has_verdict, v);
        if (has_verdict) verdicts_due.push_back(v);
      end
      if (out_if.valid && out_if.ready) begin
        if (verdicts_due.size() == 0) begin
          if (bad_verdicts < 10)
            $display("unexpected verdict: balanced %0b error_kind %0d",
                     out_if.balanced, out_if.error_kind);
          bad_verdicts++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_if.balanced !== want.balanced || out_if.error_kind !== want.error_kind) begin
            if (bad_verdicts < 10)
              $display("verdict mismatch: balanced exp %0b got %0b, error_kind exp %0d got %0d",
                       want.balanced, out_if.balanced, want.error_kind, out_if.error_kind);
            bad_verdicts++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL bracket_balance_checker");
        $finish;
      end
    end
  end

endmodule
